// File: rtl/ccbcd_pkg.sv
package ccbcd_pkg;

  // reset value of the divisor register
  localparam int unsigned RESET_DIVISOR = 500000;

  // elapsed hundredths per second, minute and hour
  localparam int unsigned PER_SECOND = 100;
  localparam int unsigned PER_MINUTE = 60 * PER_SECOND;
  localparam int unsigned PER_HOUR   = 60 * PER_MINUTE;

  // width of a hundredths count below one hour (360000 < 2**19)
  localparam int unsigned TICK_W = 19;

  // restoring steps for minutes and for seconds (each value is below 64)
  localparam int unsigned MIN_STEPS = 6;
  localparam int unsigned SEC_STEPS = 6;

  // one transaction in the split-up part of the pipeline
  typedef struct packed {
    logic [TICK_W-1:0] rest;
    logic [5:0]        mins;
    logic [5:0]        secs;
  } split_t;

  // value 0..99 to two packed bcd digits, tens by reciprocal of ten
  function automatic logic [7:0] to_bcd2(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - (7'(tens) * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

// File: rtl/cycle_count_to_bcd_clock.sv
// Stopwatch display converter.
// The input channel (in_valid / in_ready / in_elapsed_cycles) takes a sampled
// cycle count. The block divides it by cycles_per_hundredth, drops whole
// hours and returns minutes, seconds and hundredths as packed bcd digits on
// the output channel (out_valid / out_ready / out_*_bcd), one result per
// transaction and in order. A divisor of zero gives all-zero digits.
// The user must set the divisor through cfg_we / cfg_wdata only while no
// transaction is in flight; the block does not enforce this. It resets to 500000.
// The pipeline has one restoring divider stage per quotient bit, which also
// keeps the quotient modulo one hour, then six stages for minutes, six for
// seconds and one register for the bcd digits.
// Throughput is one transaction per cycle. All stages advance together:
// when the output holds a result that is not taken, the whole pipeline and
// in_ready stall, and nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// divisor.
module cycle_count_to_bcd_clock #(
  parameter int COUNT_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COUNT_WIDTH-1:0] in_elapsed_cycles,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             out_minutes_bcd,
  output logic [6:0]             out_seconds_bcd,
  output logic [7:0]             out_hundredths_bcd
);

  localparam int W     = COUNT_WIDTH;
  localparam int TW    = ccbcd_pkg::TICK_W;
  localparam int NMIN  = ccbcd_pkg::MIN_STEPS;
  localparam int NPOST = ccbcd_pkg::MIN_STEPS + ccbcd_pkg::SEC_STEPS;
  localparam logic [63:0] RESET_DIV64 = 64'(ccbcd_pkg::RESET_DIVISOR);
  localparam logic [TW:0] HOUR_W      = (TW + 1)'(ccbcd_pkg::PER_HOUR);

  logic [W-1:0] divisor_r;
  logic         adv;

  // divider pipeline registers, index k holds the output of step k-1
  logic [W-1:0]  rem_r [1:W];
  logic [W-1:0]  dvd_r [1:W];
  logic [TW-1:0] qm_r  [1:W];
  logic          dvld_r [1:W];

  // split pipeline registers
  ccbcd_pkg::split_t post_r [1:NPOST];
  logic              pvld_r [1:NPOST];

  logic              out_valid_r;
  logic [6:0]        out_minutes_r;
  logic [6:0]        out_seconds_r;
  logic [7:0]        out_hundredths_r;

  // whole pipeline moves unless a finished result is waiting
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // divisor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= RESET_DIV64[W-1:0];
    end else if (cfg_we) begin
      divisor_r <= cfg_wdata;
    end
  end

  // restoring division, one quotient bit per stage, quotient kept mod one hour
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W-1:0]  rem_in;
    logic [W-1:0]  dvd_in;
    logic [TW-1:0] qm_in;
    logic          vld_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          qbit;
    logic [TW:0]   qm_sh;
    logic [TW:0]   qm_sub;

    if (k == 0) begin : g_src
      assign rem_in = '0;
      assign dvd_in = in_elapsed_cycles;
      assign qm_in  = '0;
      assign vld_in = in_valid;
    end else begin : g_src
      assign rem_in = rem_r[k];
      assign dvd_in = dvd_r[k];
      assign qm_in  = qm_r[k];
      assign vld_in = dvld_r[k];
    end

    assign trial  = {rem_in, dvd_in[W-1]};
    assign diff   = trial - {1'b0, divisor_r};
    assign qbit   = (trial >= {1'b0, divisor_r});
    assign qm_sh  = {qm_in, qbit};
    assign qm_sub = qm_sh - HOUR_W;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dvld_r[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= qbit ? diff[W-1:0] : trial[W-1:0];
        dvd_r[k+1] <= {dvd_in[W-2:0], 1'b0};
        qm_r[k+1]  <= (qm_sh >= HOUR_W) ? qm_sub[TW-1:0] : qm_sh[TW-1:0];
      end
    end
  end

  // minutes then seconds by restoring subtraction of shifted constants
  for (genvar j = 0; j < NPOST; j++) begin : g_split
    localparam int unsigned STEP_INT = (j < NMIN)
        ? (ccbcd_pkg::PER_MINUTE << (NMIN - 1 - j))
        : (ccbcd_pkg::PER_SECOND << (NPOST - 1 - j));
    localparam logic [TW-1:0] STEP = TW'(STEP_INT);

    ccbcd_pkg::split_t cur;
    ccbcd_pkg::split_t nxt;
    logic              vld_in;
    logic              take;

    if (j == 0) begin : g_src
      assign cur    = '{rest: qm_r[W], mins: 6'd0, secs: 6'd0};
      assign vld_in = dvld_r[W];
    end else begin : g_src
      assign cur    = post_r[j];
      assign vld_in = pvld_r[j];
    end

    assign take = (cur.rest >= STEP);

    always_comb begin
      nxt      = cur;
      nxt.rest = take ? (cur.rest - STEP) : cur.rest;
      if (j < NMIN) begin
        nxt.mins = {cur.mins[4:0], take};
      end else begin
        nxt.secs = {cur.secs[4:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pvld_r[j+1] <= 1'b0;
      end else if (adv) begin
        pvld_r[j+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        post_r[j+1] <= nxt;
      end
    end
  end

  // bcd digits into the output register, zero divisor gives zeros
  logic [7:0] min_bcd;
  logic [7:0] sec_bcd;
  logic [7:0] hun_bcd;
  logic       div_zero;

  assign div_zero = (divisor_r == '0);
  assign min_bcd  = ccbcd_pkg::to_bcd2({1'b0, post_r[NPOST].mins});
  assign sec_bcd  = ccbcd_pkg::to_bcd2({1'b0, post_r[NPOST].secs});
  assign hun_bcd  = ccbcd_pkg::to_bcd2(post_r[NPOST].rest[6:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pvld_r[NPOST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_minutes_r    <= div_zero ? 7'd0 : min_bcd[6:0];
      out_seconds_r    <= div_zero ? 7'd0 : sec_bcd[6:0];
      out_hundredths_r <= div_zero ? 8'd0 : hun_bcd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_minutes_bcd    = out_minutes_r;
  assign out_seconds_bcd    = out_seconds_r;
  assign out_hundredths_bcd = out_hundredths_r;

  // quotient residue stays below one hour
  a_qm_range: assert property (@(posedge clk) disable iff (!rst_n)
    dvld_r[W] |-> (qm_r[W] < TW'(ccbcd_pkg::PER_HOUR)))
    else $error("quotient residue not below one hour");

  // after the minute steps less than one minute is left
  a_min_rest: assert property (@(posedge clk) disable iff (!rst_n)
    pvld_r[NMIN] |-> (post_r[NMIN].rest < TW'(ccbcd_pkg::PER_MINUTE)))
    else $error("minute split left a full minute");

  // after the second steps less than one second is left
  a_sec_rest: assert property (@(posedge clk) disable iff (!rst_n)
    pvld_r[NPOST] |-> (post_r[NPOST].rest < TW'(ccbcd_pkg::PER_SECOND)))
    else $error("second split left a full second");

  // hundredths digits are legal bcd, seconds and minutes tens digits are at most 5
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hundredths_r[3:0] <= 4'd9 && out_hundredths_r[7:4] <= 4'd9
                     && out_seconds_r[6:4] <= 3'd5 && out_minutes_r[6:4] <= 3'd5))
    else $error("output digit out of range");

  // pipeline only stalls behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

endmodule
